// ===== hdl/cbb_pkg.sv =====
// Shared types and constants of the clamped RGB box blur.
package cbb_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_RADIUS  = 8;
   localparam int ROW_SLOTS   = 2 * MAX_RADIUS + 2;
   localparam int STORE_DEPTH = ROW_SLOTS * MAX_WIDTH;
   localparam int COL_BITS    = $clog2(MAX_WIDTH);
   localparam int SLOT_BITS   = $clog2(ROW_SLOTS);
   localparam int ADDR_BITS   = SLOT_BITS + COL_BITS;
   localparam int SUM_BITS    = 25;
   localparam int CNT_BITS    = 9;
   localparam int POS_BITS    = 26;
   localparam int CH_BITS     = 16;

   localparam logic [1:0] CSR_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_RADIUS = 2'd2;

   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_DRAIN = 1'b1;

   typedef struct packed {
      logic         command;
      logic [15:0]  in_red;
      logic [15:0]  in_green;
      logic [15:0]  in_blue;
   } req_word_type;

   typedef struct packed {
      logic [15:0]  out_red;
      logic [15:0]  out_green;
      logic [15:0]  out_blue;
      logic         last;
   } rsp_word_type;

   typedef struct packed {
      logic clear;
      logic acc;
      logic start;
   } lane_ctl_type;

endpackage

// ===== hdl/clamped_box_blur_rgb.sv =====
// Top level of the clamped RGB box blur with its sequencer and result register.
//
// The block takes RGB pixels of one frame in raster order and returns, for
// each pixel, the floored mean of the square window of side 2*radius+1
// around it, clipped at the frame edges, with the clipped area as divisor.
// A result appears once the pixel radius rows plus radius pixels later has
// been taken; drain words (command = 1) after the last pixel flush the
// remaining results one at a time, and the last flag marks the final pixel.
// A pixel that yields no result does not stall the input. One that yields a
// result keeps the input stalled while its clipped window (at most 289
// pixels) is read from the row store one pixel per cycle over its single
// read port, and three side-by-side channel lanes then divide the sums one
// quotient bit per cycle. The finished word waits in an output register, so
// the next word can be taken while it is still stalled downstream. Writing
// the width, height or radius register aborts the frame in progress;
// registers are written only while the block is idle.
module clamped_box_blur_rgb
   import cbb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_data,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [15:0]  csr_wdata
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SETUP = 3'd1;
   localparam logic [2:0] S_READ  = 3'd2;
   localparam logic [2:0] S_TAIL  = 3'd3;
   localparam logic [2:0] S_DIVGO = 3'd4;
   localparam logic [2:0] S_DIV   = 3'd5;
   localparam logic [2:0] S_PUSH  = 3'd6;

   // Configuration registers and the figures derived from them.
   logic [10:0] width_ff, width_in;
   logic [15:0] height_ff, height_in;
   logic [3:0]  radius_ff, radius_in;
   logic [10:0] w_eff;
   logic [15:0] h_eff;
   logic [3:0]  r_eff;
   logic [POS_BITS-1:0] total, lag;

   logic [2:0] state_ff, state_in;

   // Frame positions.
   logic [POS_BITS-1:0]  in_pos_ff, in_pos_in, out_pos_ff, out_pos_in;
   logic [COL_BITS-1:0]  in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [SLOT_BITS-1:0] in_slot_ff, in_slot_in, out_slot_ff, out_slot_in;
   logic [15:0]          out_row_ff, out_row_in;
   logic                 last_ff, last_in;

   // Window walk.
   logic [COL_BITS-1:0]  x0_ff, x0_in, x1_ff, x1_in, xcur_ff, xcur_in;
   logic [SLOT_BITS-1:0] yslot_ff, yslot_in;
   logic [4:0]           yleft_ff, yleft_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic                 rd_vld_ff;

   // Result register.
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_data_ff, rsp_data_in;

   logic req_fire, csr_fire, rd_en, push;
   logic [47:0] wr_data, rd_data;
   lane_ctl_type lane_ctl;
   logic [2:0] lane_busy;
   logic [CH_BITS-1:0] q_red, q_green, q_blue;

   // Setup arithmetic.
   logic [16:0] oy_hi, h_m1;
   logic [15:0] y0, y1;
   logic [11:0] ox_hi, w_m1;
   logic [COL_BITS-1:0] sx0, sx1;
   logic [4:0] ydist, yspan, xspan;
   logic [9:0] area;

   // The frame size and output lag follow the registers in the same cycle, so
   // a word taken straight after a register write already sees the new frame.
   always_comb begin
      w_eff = (width_ff == 11'd0) ? 11'd1 :
              (width_ff > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : width_ff;
      h_eff = (height_ff == 16'd0) ? 16'd1 : height_ff;
      r_eff = (radius_ff > 4'(MAX_RADIUS)) ? 4'(MAX_RADIUS) : radius_ff;
      total = POS_BITS'(w_eff) * POS_BITS'(h_eff);
      lag   = POS_BITS'(r_eff) * POS_BITS'(w_eff) + POS_BITS'(r_eff);
   end

   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign csr_fire  = csr_valid && csr_ready;
   assign wr_data   = {req_data.in_blue, req_data.in_green, req_data.in_red};
   assign rd_en     = (state_ff == S_READ);
   assign push      = (state_ff == S_PUSH) && (!rsp_valid_ff || !rsp_stall);

   // Clipped window bounds of the pixel due out.
   always_comb begin
      oy_hi = {1'b0, out_row_ff} + 17'(r_eff);
      h_m1  = 17'(h_eff) - 17'd1;
      y0    = (out_row_ff > 16'(r_eff)) ? out_row_ff - 16'(r_eff) : 16'd0;
      y1    = (oy_hi < h_m1) ? oy_hi[15:0] : h_m1[15:0];
      ox_hi = {2'b00, out_col_ff} + 12'(r_eff);
      w_m1  = 12'(w_eff) - 12'd1;
      sx0   = (out_col_ff > COL_BITS'(r_eff)) ? out_col_ff - COL_BITS'(r_eff) : '0;
      sx1   = (ox_hi < w_m1) ? ox_hi[COL_BITS-1:0] : w_m1[COL_BITS-1:0];
      ydist = 5'(out_row_ff - y0);
      yspan = 5'(y1 - y0);
      xspan = 5'(sx1 - sx0) + 5'd1;
      area  = xspan * (yspan + 5'd1);
   end

   always_comb begin
      state_in     = state_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      radius_in    = radius_ff;
      in_pos_in    = in_pos_ff;
      in_col_in    = in_col_ff;
      in_slot_in   = in_slot_ff;
      out_pos_in   = out_pos_ff;
      out_col_in   = out_col_ff;
      out_row_in   = out_row_ff;
      out_slot_in  = out_slot_ff;
      last_in      = last_ff;
      x0_in        = x0_ff;
      x1_in        = x1_ff;
      xcur_in      = xcur_ff;
      yslot_in     = yslot_ff;
      yleft_in     = yleft_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      lane_ctl     = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_data.command == CMD_PIXEL) begin
                  if (in_pos_ff < total) begin
                     in_pos_in = in_pos_ff + POS_BITS'(1);
                     if ({1'b0, in_col_ff} == w_eff - 11'd1) begin
                        in_col_in  = '0;
                        in_slot_in = (in_slot_ff == SLOT_BITS'(ROW_SLOTS - 1)) ?
                                     '0 : in_slot_ff + SLOT_BITS'(1);
                     end else begin
                        in_col_in = in_col_ff + COL_BITS'(1);
                     end
                     if (in_pos_ff >= lag && out_pos_ff < total) begin
                        state_in = S_SETUP;
                     end
                  end
               end else if (in_pos_ff == total && out_pos_ff < total) begin
                  state_in = S_SETUP;
               end
            end
         end
         S_SETUP: begin
            x0_in    = sx0;
            x1_in    = sx1;
            xcur_in  = sx0;
            yleft_in = yspan;
            count_in = area[CNT_BITS-1:0];
            yslot_in = (out_slot_ff >= ydist) ? out_slot_ff - ydist :
                       SLOT_BITS'(out_slot_ff + SLOT_BITS'(ROW_SLOTS) - ydist);
            last_in  = (out_pos_ff == total - POS_BITS'(1));
            lane_ctl.clear = 1'b1;
            state_in = S_READ;
         end
         S_READ: begin
            lane_ctl.acc = rd_vld_ff;
            if (xcur_ff == x1_ff) begin
               xcur_in  = x0_ff;
               yslot_in = (yslot_ff == SLOT_BITS'(ROW_SLOTS - 1)) ?
                          '0 : yslot_ff + SLOT_BITS'(1);
               yleft_in = yleft_ff - 5'd1;
               if (yleft_ff == 5'd0) begin
                  state_in = S_TAIL;
               end
            end else begin
               xcur_in = xcur_ff + COL_BITS'(1);
            end
         end
         S_TAIL: begin
            lane_ctl.acc = rd_vld_ff;
            state_in = S_DIVGO;
         end
         S_DIVGO: begin
            lane_ctl.start = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (lane_busy == 3'b000) begin
               state_in = S_PUSH;
            end
         end
         S_PUSH: begin
            if (push) begin
               // Merge the three lane quotients with the frame end flag.
               rsp_valid_in          = 1'b1;
               rsp_data_in.out_red   = q_red;
               rsp_data_in.out_green = q_green;
               rsp_data_in.out_blue  = q_blue;
               rsp_data_in.last      = last_ff;
               state_in = S_IDLE;
               if (last_ff) begin
                  in_pos_in   = '0;
                  in_col_in   = '0;
                  in_slot_in  = '0;
                  out_pos_in  = '0;
                  out_col_in  = '0;
                  out_row_in  = '0;
                  out_slot_in = '0;
               end else begin
                  out_pos_in = out_pos_ff + POS_BITS'(1);
                  if ({1'b0, out_col_ff} == w_eff - 11'd1) begin
                     out_col_in  = '0;
                     out_row_in  = out_row_ff + 16'd1;
                     out_slot_in = (out_slot_ff == SLOT_BITS'(ROW_SLOTS - 1)) ?
                                   '0 : out_slot_ff + SLOT_BITS'(1);
                  end else begin
                     out_col_in = out_col_ff + COL_BITS'(1);
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // A write to the width, height or radius register restarts the frame.
      if (csr_fire) begin
         case (csr_index)
            CSR_WIDTH:  width_in  = csr_wdata[10:0];
            CSR_HEIGHT: height_in = csr_wdata;
            CSR_RADIUS: radius_in = csr_wdata[3:0];
            default:    ;
         endcase
         if (csr_index == CSR_WIDTH || csr_index == CSR_HEIGHT ||
             csr_index == CSR_RADIUS) begin
            in_pos_in   = '0;
            in_col_in   = '0;
            in_slot_in  = '0;
            out_pos_in  = '0;
            out_col_in  = '0;
            out_row_in  = '0;
            out_slot_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         width_ff     <= 11'd640;
         height_ff    <= 16'd480;
         radius_ff    <= 4'd2;
         in_pos_ff    <= '0;
         in_col_ff    <= '0;
         in_slot_ff   <= '0;
         out_pos_ff   <= '0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         out_slot_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         radius_ff    <= radius_in;
         in_pos_ff    <= in_pos_in;
         in_col_ff    <= in_col_in;
         in_slot_ff   <= in_slot_in;
         out_pos_ff   <= out_pos_in;
         out_col_ff   <= out_col_in;
         out_row_ff   <= out_row_in;
         out_slot_ff  <= out_slot_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_vld_ff    <= rd_en;
      end
   end

   // The window walk and the result payload need no reset.
   always_ff @(posedge clock) begin
      last_ff     <= last_in;
      x0_ff       <= x0_in;
      x1_ff       <= x1_in;
      xcur_ff     <= xcur_in;
      yslot_ff    <= yslot_in;
      yleft_ff    <= yleft_in;
      count_ff    <= count_in;
      rsp_data_ff <= rsp_data_in;
   end

   cbb_row_store u_store (
      .clock   (clock),
      .wr_en   (req_fire && req_data.command == CMD_PIXEL && in_pos_ff < total),
      .wr_addr ({in_slot_ff, in_col_ff}),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr ({yslot_ff, xcur_ff}),
      .rd_data (rd_data)
   );

   cbb_lane u_lane_red (
      .clock    (clock),
      .reset    (reset),
      .ctl      (lane_ctl),
      .sample   (rd_data[15:0]),
      .divisor  (count_ff),
      .busy     (lane_busy[0]),
      .quotient (q_red)
   );

   cbb_lane u_lane_green (
      .clock    (clock),
      .reset    (reset),
      .ctl      (lane_ctl),
      .sample   (rd_data[31:16]),
      .divisor  (count_ff),
      .busy     (lane_busy[1]),
      .quotient (q_green)
   );

   cbb_lane u_lane_blue (
      .clock    (clock),
      .reset    (reset),
      .ctl      (lane_ctl),
      .sample   (rd_data[47:32]),
      .divisor  (count_ff),
      .busy     (lane_busy[2]),
      .quotient (q_blue)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hdl/cbb_row_store.sv =====
// Row store memory: one write and one registered read per cycle.
module cbb_row_store
   import cbb_pkg::*;
(
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [47:0]          wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [47:0]          rd_data
);

   logic [47:0] mem [STORE_DEPTH];
   logic [47:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/cbb_lane.sv =====
// One colour lane: window accumulator and a bit-serial restoring divider.
module cbb_lane
   import cbb_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  lane_ctl_type        ctl,
   input  logic [CH_BITS-1:0]  sample,
   input  logic [CNT_BITS-1:0] divisor,
   output logic                busy,
   output logic [CH_BITS-1:0]  quotient
);

   logic [SUM_BITS-1:0] sum_ff, sum_in;
   logic [SUM_BITS-1:0] quo_ff, quo_in;
   logic [CNT_BITS-1:0] rem_ff, rem_in;
   logic [4:0]          cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic [CNT_BITS:0]   trial;

   always_comb begin
      sum_in  = sum_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff, quo_ff[SUM_BITS-1]};
      if (ctl.clear) begin
         sum_in = '0;
      end else if (ctl.acc) begin
         sum_in = sum_ff + SUM_BITS'(sample);
      end
      if (ctl.start) begin
         quo_in  = sum_ff;
         rem_in  = '0;
         cnt_in  = 5'(SUM_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // Shift one dividend bit in and subtract where the divisor fits.
         if (trial >= {1'b0, divisor}) begin
            rem_in = CNT_BITS'(trial - {1'b0, divisor});
            quo_in = {quo_ff[SUM_BITS-2:0], 1'b1};
         end else begin
            rem_in = trial[CNT_BITS-1:0];
            quo_in = {quo_ff[SUM_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff[CH_BITS-1:0];

endmodule

// ===== hdl/cbb_checker.sv =====
// Port-level checks of the clamped RGB box blur, bound to its top level.
module cbb_checker
   import cbb_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_word_type rsp_data,
   input logic         csr_ready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("Stalled result word changed or vanished.");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Result word valid straight after reset.");

   a_csr_idle: assert property (@(posedge clock) disable iff (reset)
      csr_ready != req_stall)
      else $error("Register port ready does not match an idle input side.");

   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("Result word appeared without the block having been busy.");

endmodule

bind clamped_box_blur_rgb cbb_checker u_checker (.*);

// ===== verif/clamped_box_blur_rgb_checker.sv =====
// Checker for the clamped RGB box blur: predicts the window means and compares them.
`timescale 1ns / 100ps

module clamped_box_blur_rgb_checker
   import cbb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_stall,
   input  req_word_type req_data,
   input  logic         rsp_valid,
   input  logic         rsp_stall,
   input  rsp_word_type rsp_data,
   input  logic         csr_valid,
   input  logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [15:0]  csr_wdata,
   output int           pending,
   output int           mismatches
);

   logic [15:0] red_rows   [STORE_DEPTH];
   logic [15:0] green_rows [STORE_DEPTH];
   logic [15:0] blue_rows  [STORE_DEPTH];

   int unsigned width_reg, height_reg, radius_reg;
   int unsigned in_pos, out_pos;
   rsp_word_type blur_q[$];

   function automatic int unsigned eff_w();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_WIDTH) return MAX_WIDTH;
      return width_reg;
   endfunction

   function automatic int unsigned eff_h();
      return (height_reg == 0) ? 1 : height_reg;
   endfunction

   function automatic int unsigned eff_r();
      return (radius_reg > MAX_RADIUS) ? MAX_RADIUS : radius_reg;
   endfunction

   // Sums the clipped window around the next output pixel and queues its means.
   function automatic void emit_mean(int unsigned w, int unsigned h, int unsigned r,
                                     int unsigned total);
      int unsigned ox, oy, x0, x1, y0, y1, sr, sg, sb, cnt, a;
      rsp_word_type res;
      ox = out_pos % w;
      oy = out_pos / w;
      y0 = (oy > r) ? oy - r : 0;
      y1 = (oy + r < h - 1) ? oy + r : h - 1;
      x0 = (ox > r) ? ox - r : 0;
      x1 = (ox + r < w - 1) ? ox + r : w - 1;
      sr = 0; sg = 0; sb = 0;
      for (int unsigned y = y0; y <= y1; y++) begin
         for (int unsigned x = x0; x <= x1; x++) begin
            a = (y % ROW_SLOTS) * MAX_WIDTH + x;
            sr += red_rows[a];
            sg += green_rows[a];
            sb += blue_rows[a];
         end
      end
      cnt = (x1 - x0 + 1) * (y1 - y0 + 1);
      res.out_red   = 16'(sr / cnt);
      res.out_green = 16'(sg / cnt);
      res.out_blue  = 16'(sb / cnt);
      res.last      = (out_pos == total - 1);
      blur_q.push_back(res);
      out_pos++;
      if (res.last) begin
         in_pos  = 0;
         out_pos = 0;
      end
   endfunction

   function automatic void take_word(req_word_type wd);
      int unsigned w, h, r, total, lag, a;
      w = eff_w();
      h = eff_h();
      r = eff_r();
      total = w * h;
      lag = r * w + r;
      if (wd.command == CMD_PIXEL) begin
         if (in_pos >= total) return;
         a = ((in_pos / w) % ROW_SLOTS) * MAX_WIDTH + in_pos % w;
         red_rows[a]   = wd.in_red;
         green_rows[a] = wd.in_green;
         blue_rows[a]  = wd.in_blue;
         in_pos++;
         if (in_pos > lag && out_pos < total) emit_mean(w, h, r, total);
      end else if (in_pos == total && out_pos < total) begin
         emit_mean(w, h, r, total);
      end
   endfunction

   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         width_reg  = 640;
         height_reg = 480;
         radius_reg = 2;
         in_pos     = 0;
         out_pos    = 0;
         mismatches = 0;
         blur_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (blur_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected result word %h", $realtime, rsp_data);
            end else begin
               want = blur_q.pop_front();
               if (rsp_data.out_red !== want.out_red || rsp_data.out_green !== want.out_green
                   || rsp_data.out_blue !== want.out_blue || rsp_data.last !== want.last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: expected r %h g %h b %h last %b, got r %h g %h b %h last %b",
                              $realtime, want.out_red, want.out_green, want.out_blue,
                              want.last, rsp_data.out_red, rsp_data.out_green,
                              rsp_data.out_blue, rsp_data.last);
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_WIDTH:  width_reg  = csr_wdata & 16'h07FF;
               CSR_HEIGHT: height_reg = csr_wdata;
               CSR_RADIUS: radius_reg = csr_wdata & 16'h000F;
               default: ;
            endcase
            if (csr_index inside {CSR_WIDTH, CSR_HEIGHT, CSR_RADIUS}) begin
               in_pos  = 0;
               out_pos = 0;
            end
         end
         if (req_valid && !req_stall) take_word(req_data);
      end
      pending = blur_q.size();
   end

endmodule

// ===== verif/clamped_box_blur_rgb_tb.sv =====
// Testbench top of the clamped RGB box blur: stimulus, idling phases and verdict.
`timescale 1ns / 100ps

module clamped_box_blur_rgb_tb;
   import cbb_pkg::*;

   // Idle margin after the last expected word; it covers the slowest result, a 289 pixel window.
   localparam int SETTLE_CYCLES = 400;
   localparam int RANDOM_ITEMS  = 1950;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_data;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [1:0]   csr_index = CSR_WIDTH;
   logic [15:0]  csr_wdata = '0;
   int           pending;
   int           mismatches;

   // Idling percentages of the current phase, and the long receiver hold-off.
   int           send_idle_pct = 0;
   int           recv_stall_pct = 0;
   bit           hold_rsp = 1'b0;
   int           items_sent = 0;

   always #5 clock = ~clock;

   clamped_box_blur_rgb dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   clamped_box_blur_rgb_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata),
      .pending(pending), .mismatches(mismatches)
   );

   // The receiver stalls at random each cycle, or throughout a hold-off.
   always @(posedge clock) begin
      rsp_stall <= hold_rsp || ($urandom_range(99) < recv_stall_pct);
   end

   // Offers one word, after a random gap, and returns at the edge that takes it.
   // The valid is left high so that back-to-back words need no second assignment.
   task automatic send_word(input req_word_type wd);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= wd;
      do @(posedge clock); while (req_stall);
   endtask

   // A pixel word; now and then every channel is pinned to an extreme.
   function automatic req_word_type pixel_word();
      req_word_type wd;
      wd.command = CMD_PIXEL;
      wd.in_red   = 16'($urandom);
      wd.in_green = 16'($urandom);
      wd.in_blue  = 16'($urandom);
      case ($urandom_range(7))
         0: begin wd.in_red = '0; wd.in_green = '0; wd.in_blue = '0; end
         1: begin wd.in_red = '1; wd.in_green = '1; wd.in_blue = '1; end
         default: ;
      endcase
      return wd;
   endfunction

   function automatic req_word_type drain_word();
      req_word_type wd;
      wd = req_word_type'({$urandom, $urandom});
      wd.command = CMD_DRAIN;
      return wd;
   endfunction

   // Waits until every expected word has come back and the block has gone quiet.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Sets up a frame and streams up to pix_limit of its pixels; a whole frame is
   // then drained to its last word. Spare drains before the end and spare pixels
   // while draining are mixed in, since the block must ignore both.
   task automatic run_frame(input int unsigned w, input int unsigned h,
                            input int unsigned r, input int unsigned pix_limit);
      int unsigned ew, eh, er, total, npix, ndrain;
      wait_idle();
      // Upper data bits beyond the width and radius registers' widths are filled at random.
      write_reg(CSR_WIDTH,  16'(w) | (16'($urandom) & 16'hF800));
      write_reg(CSR_HEIGHT, 16'(h));
      write_reg(CSR_RADIUS, 16'(r) | (16'($urandom) & 16'hFFF0));
      ew = (w == 0) ? 1 : (w > MAX_WIDTH) ? MAX_WIDTH : w;
      eh = (h == 0) ? 1 : h;
      er = (r > MAX_RADIUS) ? MAX_RADIUS : r;
      total = ew * eh;
      npix = (total < pix_limit) ? total : pix_limit;
      for (int unsigned i = 0; i < npix; i++) begin
         if ($urandom_range(15) == 0) send_word(drain_word());
         send_word(pixel_word());
         items_sent++;
      end
      if (npix == total) begin
         ndrain = (er * ew + er < total) ? er * ew + er : total;
         for (int unsigned i = 0; i < ndrain; i++) begin
            if ($urandom_range(9) == 0) send_word(pixel_word());
            send_word(drain_word());
            items_sent++;
         end
         // Nothing is pending any more, so this drain does nothing.
         if ($urandom_range(3) == 0) send_word(drain_word());
      end
      req_valid <= 1'b0;
   endtask

   initial begin
      int unsigned w, h, r, phase;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed frames: the register extremes, values out of range, and
      // windows clipped on every side.
      run_frame(1, 1, 0, 4);
      run_frame(3, 3, 8, 9);
      run_frame(1024, 65535, 0, 12);
      run_frame(1024, 65535, 8, 6);
      run_frame(0, 0, 15, 4);
      run_frame(2047, 1, 0, 5);
      run_frame(5, 4, 1, 25);

      // Long receiver hold-off while pixels keep coming, so the block backs up
      // and stalls its input; then the sender pauses mid-frame until all is back.
      fork
         begin
            hold_rsp = 1'b1;
            repeat (800) @(posedge clock);
            hold_rsp = 1'b0;
         end
         run_frame(16, 3, 0, 48);
      join
      run_frame(4, 4, 2, 8);
      wait_idle();
      for (int i = 0; i < 8; i++) send_word(pixel_word());
      send_word(drain_word());
      req_valid <= 1'b0;
      items_sent = 0;

      // Random frames through four idling phases.
      while (items_sent < RANDOM_ITEMS) begin
         phase = items_sent * 4 / RANDOM_ITEMS;
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
            default: begin send_idle_pct = 32; recv_stall_pct = 32; end
         endcase
         w = ($urandom_range(4) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
         h = $urandom_range(1, 6);
         r = $urandom_range(0, 9);
         case ($urandom_range(19))
            0: w = 0;
            1: h = 0;
            2: begin w = $urandom_range(1025, 2047); h = 1; end
            default: ;
         endcase
         // Most frames run to the end; a few are cut off by the next set-up.
         run_frame(w, h, r, ($urandom_range(9) == 0) ? $urandom_range(1, 20) : 32'hFFFF_FFFF);
      end

      wait_idle();
      if (mismatches == 0 && pending == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #50_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/cbb_pkg.sv
hdl/cbb_row_store.sv
hdl/cbb_lane.sv
hdl/clamped_box_blur_rgb.sv
hdl/cbb_checker.sv
verif/clamped_box_blur_rgb_checker.sv
verif/clamped_box_blur_rgb_tb.sv
